### sv/transceiver_presence_fsm_macros.svh
// Assertion macros shared by the transceiver presence manager modules.
`ifndef TRANSCEIVER_PRESENCE_FSM_MACROS_SVH
`define TRANSCEIVER_PRESENCE_FSM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tpf_pkg.sv
// Types, constants and decode function of the transceiver presence manager.
package tpf_pkg;

    localparam int NUM_PORTS  = 16;
    localparam int PORT_W     = 4;
    localparam int ATT_W      = 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    typedef enum logic [2:0] {
        ST_REMOVED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_PENDING  = 3'd2,
        ST_READ     = 3'd3,
        ST_READ_ERR = 3'd4
    } t_port_state;

    typedef enum logic [1:0] {
        EV_REMOVED  = 2'd0,
        EV_INSERTED = 2'd1,
        EV_DONE     = 2'd2,
        EV_ERROR    = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        MT_UNKNOWN = 2'd0,
        MT_SFP     = 2'd1,
        MT_QSFP    = 2'd2,
        MT_QSFP28  = 2'd3
    } t_mod_type;

    localparam logic [7:0] ID_SFP     = 8'h03;
    localparam logic [7:0] ID_QSFP    = 8'h0c;
    localparam logic [7:0] ID_QSFP_P  = 8'h0d;
    localparam logic [7:0] ID_QSFP28  = 8'h11;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        t_event_kind       kind;
        t_mod_type         mtype;
        logic              last;
    } t_event;

    typedef struct packed {
        logic [1:0] cnt;
        t_event     ev0;
        t_event     ev1;
    } t_push;

    function automatic t_mod_type decode_type(input logic [7:0] id);
        t_mod_type t;
        unique case (id)
            ID_SFP:             t = MT_SFP;
            ID_QSFP, ID_QSFP_P: t = MT_QSFP;
            ID_QSFP28:          t = MT_QSFP28;
            default:            t = MT_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

### sv/tpf_port_table.sv
// Poll register, per-port state table and event generation.
module tpf_port_table
    import tpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PORT_W-1:0] i_port,
    input  logic              i_present,
    input  logic              i_read_ok,
    input  logic [7:0]        i_id_byte,
    input  logic              i_cfg_wr_en,
    input  logic [ATT_W-1:0]  i_cfg_wr_data,
    input  logic              i_room,
    output t_push             o_push
);

`include "transceiver_presence_fsm_macros.svh"

    logic              r_in_valid;
    logic [PORT_W-1:0] r_port;
    logic              r_present;
    logic              r_read_ok;
    logic [7:0]        r_id_byte;
    logic [ATT_W-1:0]  r_max_att;

    t_port_state       r_state [NUM_PORTS];
    logic              r_db    [NUM_PORTS];
    logic [ATT_W-1:0]  r_att   [NUM_PORTS];

    logic              proc;
    logic              port_ok;
    t_port_state       cur_st;
    t_port_state       n_st;
    logic              cur_db;
    logic              n_db;
    logic [ATT_W-1:0]  cur_att;
    logic [ATT_W-1:0]  n_att;
    logic [ATT_W-1:0]  att_inc;
    logic [ATT_W-1:0]  lim;
    logic              mismatch;
    logic              change;
    logic              try_read;
    t_mod_type         ty;
    t_event            ev_chg;
    t_event            ev_rd;
    logic              rd_ev;

    assign port_ok = ({1'b0, r_port} < (PORT_W+1)'(NUM_PORTS));
    assign proc    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_att  <= ATT_W'(10);
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (i_cfg_wr_en) begin
                r_max_att <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_port    <= i_port;
            r_present <= i_present;
            r_read_ok <= i_read_ok;
            r_id_byte <= i_id_byte;
        end
    end

    always_comb begin
        cur_st   = r_state[r_port];
        cur_db   = r_db[r_port];
        cur_att  = r_att[r_port];
        ty       = decode_type(r_id_byte);
        mismatch = r_present ? (cur_st == ST_REMOVED) : (cur_st != ST_REMOVED);
        change   = cur_db && mismatch;
        n_db     = !cur_db && mismatch;
        n_st     = change ? (r_present ? ST_INSERTED : ST_REMOVED) : cur_st;
        n_att    = cur_att;
        att_inc  = (cur_att == '1) ? cur_att : cur_att + ATT_W'(1);
        lim      = (r_max_att == '0) ? ATT_W'(1) : r_max_att;
        rd_ev    = 1'b0;
        try_read = (n_st == ST_PENDING) || (change && (n_st == ST_INSERTED));

        ev_chg.port  = r_port;
        ev_chg.kind  = r_present ? EV_INSERTED : EV_REMOVED;
        ev_chg.mtype = MT_UNKNOWN;
        ev_chg.last  = 1'b1;
        ev_rd.port   = r_port;
        ev_rd.kind   = EV_ERROR;
        ev_rd.mtype  = MT_UNKNOWN;
        ev_rd.last   = 1'b1;

        if (try_read) begin
            n_st = ST_PENDING;
            if (r_read_ok && (ty != MT_UNKNOWN)) begin
                n_st        = ST_READ;
                rd_ev       = 1'b1;
                ev_rd.kind  = EV_DONE;
                ev_rd.mtype = ty;
            end else begin
                n_att = att_inc;
                if (att_inc >= lim) begin
                    n_st  = ST_READ_ERR;
                    rd_ev = 1'b1;
                end
            end
        end else if (change && (n_st == ST_REMOVED)) begin
            n_att = '0;
        end

        o_push.cnt = 2'd0;
        o_push.ev0 = ev_chg;
        o_push.ev1 = ev_rd;
        if (proc && port_ok) begin
            if (change && rd_ev) begin
                o_push.cnt      = 2'd2;
                o_push.ev0.last = 1'b0;
            end else if (change) begin
                o_push.cnt = 2'd1;
            end else if (rd_ev) begin
                o_push.cnt = 2'd1;
                o_push.ev0 = ev_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_state[i] <= ST_REMOVED;
                r_db[i]    <= 1'b0;
                r_att[i]   <= '0;
            end
        end else if (proc && port_ok) begin
            r_state[r_port] <= n_st;
            r_db[r_port]    <= n_db;
            r_att[r_port]   <= n_att;
        end
    end

    `TPF_ASSERT_IMP(a_pair_starts_insert, o_push.cnt == 2'd2,
        o_push.ev0.kind == EV_INSERTED && !o_push.ev0.last && o_push.ev1.last,
        "two events from one request must start with insert")
    `TPF_ASSERT_IMP(a_done_has_type, o_push.cnt != 2'd0 && o_push.ev0.kind == EV_DONE,
        o_push.ev0.mtype != MT_UNKNOWN, "read done without module type")
    `TPF_ASSERT_IMP(a_push_needs_room, o_push.cnt != 2'd0, i_room,
        "events pushed without queue room")

endmodule

### sv/tpf_out_queue.sv
// Event queue between the port table and the output stream.
module tpf_out_queue
    import tpf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_event o_ev
);

`include "transceiver_presence_fsm_macros.svh"

    t_event            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_ev    = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    assign n_cnt   = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr + QPTR_W'(i_push.cnt);
            r_rptr <= r_rptr + QPTR_W'(pop);
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.ev0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wptr + QPTR_W'(1)] <= i_push.ev1;
        end
    end

    `TPF_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= QCNT_W'(QDEPTH), "queue overfilled")
    `TPF_ASSERT_NXT(a_pop_only, pop && i_push.cnt == 2'd0,
        r_cnt == $past(r_cnt) - QCNT_W'(1), "queue count lost on pop")
    `TPF_ASSERT_IMP(a_ptr_gap, 1'b1,
        r_cnt == QCNT_W'(QDEPTH) || QPTR_W'(r_wptr - r_rptr) == r_cnt[QPTR_W-1:0],
        "queue pointers disagree with count")

endmodule

### sv/transceiver_presence_fsm.sv
// Transceiver presence manager: top level with stream ports and register.
//
// Slave stream: one request per port poll (index, presence pin, ID read
// outcome, first ID byte). Master stream: presence and ID events, one or two
// per poll; tlast marks the final event of a poll, and a poll that changes
// nothing gives no event.
// Register: max_read_attempts, written with i_cfg_wr_en, reset value 10.
// The first event of a poll passes the poll register, then the event queue,
// before it is presented; the poll register holds while the queue lacks
// room. A second event follows when the receiver is ready.
// Throughput: one request per cycle while each poll yields at most one
// event and the receiver keeps up; the 4-entry event queue and its single
// read port set the drain rate to one event per cycle.
// Reset (i_rst_n low, synchronous): every port removed, no debounce pending,
// attempt counts zero, queue empty, register back to 10.
// Receiver stall: events hold in the queue; once fewer than two slots are
// free the held poll waits and s_tready drops.
module transceiver_presence_fsm
    import tpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // port_index[3:0], present[4], read_ok[5], id_byte[13:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // event_port[3:0], event_state[5:4], module_type[7:6]
    output logic        m_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    t_push  push;
    t_event head;
    logic   room;

    tpf_port_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_tvalid),
        .o_ready       (s_tready),
        .i_port        (s_tdata[3:0]),
        .i_present     (s_tdata[4]),
        .i_read_ok     (s_tdata[5]),
        .i_id_byte     (s_tdata[13:6]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_room        (room),
        .o_push        (push)
    );

    tpf_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_ev    (head)
    );

    assign m_tdata = {head.mtype, head.kind, head.port};
    assign m_tlast = head.last;

endmodule
